// File: hw/rtl/nearest_k_target_selector_unit_assert.svh
// Assertion macros used by the selector datapath.
// Needs clk and rst in the scope of each use.
`ifndef NEAREST_K_TARGET_SELECTOR_UNIT_ASSERT_SVH
`define NEAREST_K_TARGET_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/nksel_pkg.sv
// Shared codes, types and fixed widths of the nearest-target selector.
// No dependencies.
package nksel_pkg;

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_CAND  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;
  localparam logic [1:0] FUNC_PICK  = 2'd3;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_PICK  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [1:0] CFG_TRACK_ENABLE = 2'd0;
  localparam logic [1:0] CFG_LOCK_RANGE   = 2'd1;
  localparam logic [1:0] CFG_MAX_TARGETS  = 2'd2;

  localparam int LOCK_RANGE_W = 21;
  localparam int MAX_TGT_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int PICK_W       = 32;
  localparam logic [LOCK_RANGE_W-1:0] MIN_RANGE = 21'd2560;
  localparam logic [LOCK_RANGE_W-1:0] RANGE_RESET = 21'd12800;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQ,
    S_SUM,
    S_INS,
    S_DIV,
    S_PICK,
    S_EMIT,
    S_NONE
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       ref_load;
    logic       diff_en;
    logic       sq_en;
    logic       sum_en;
    logic       ins_en;
    logic       div_start;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_from_rem;
    logic       out_load;
    logic [1:0] out_kind;
    logic       cnt_pick;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic count_zero;
    logic pick_trivial;
    logic idx_last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/nearest_k_target_selector_unit.sv
// Streaming K-nearest target selector. A begin-scan word loads the reference.
// While tracking is enabled, a candidate word steps through accept, then
// difference, square, sum with range test and shift insertion into the sorted
// kept list. An end-scan word streams the kept entries nearest first, one per
// cycle as the output is taken; a pick word that needs a rotating index runs a
// serial 32-step remainder of the pick counter by the kept count first, and
// otherwise goes straight to its answer. No reset pass is needed.
// Depends on nksel_pkg, nksel_ctrl, nksel_dp.
module nearest_k_target_selector_unit #(
  parameter int MAX_KEPT   = 16,
  parameter int COORD_BITS = 22
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_we,
  input  logic [nksel_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [nksel_pkg::LOCK_RANGE_W-1:0]             cfg_data,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [1:0]                                     func,
  input  logic signed [COORD_BITS-1:0]                   coord_x,
  input  logic signed [COORD_BITS-1:0]                   coord_y,
  input  logic signed [COORD_BITS-1:0]                   coord_z,
  input  logic                                           usable,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [1:0]                                     kind,
  output logic [((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)-1:0] rank,
  output logic signed [COORD_BITS-1:0]                   out_x,
  output logic signed [COORD_BITS-1:0]                   out_y,
  output logic signed [COORD_BITS-1:0]                   out_z,
  output logic [2*COORD_BITS+1:0]                        dist_sq,
  output logic                                           last
);
  import nksel_pkg::*;

  cmd_t    cmd;
  status_t st;

  nksel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  nksel_dp #(.MAX_KEPT(MAX_KEPT), .COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .usable    (usable),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .rank      (rank),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .dist_sq   (dist_sq),
    .last      (last)
  );

endmodule

// File: hw/rtl/nksel_ctrl.sv
// Sequencer of the selector: decodes each word and steps the datapath.
// Depends on nksel_pkg.
module nksel_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_ready,
  input  nksel_pkg::status_t st,
  output nksel_pkg::cmd_t    cmd
);
  import nksel_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_BEGIN: state_next = S_IDLE;
            FUNC_CAND:  state_next = st.enable ? S_DIFF : S_IDLE;
            FUNC_END: begin
              if (!st.enable || st.count_zero) state_next = S_NONE;
              else state_next = S_EMIT;
            end
            default: begin
              if (!st.enable || st.count_zero) state_next = S_NONE;
              else if (st.pick_trivial) state_next = S_PICK;
              else state_next = S_DIV;
            end
          endcase
        end
      end
      S_DIFF: state_next = S_SQ;
      S_SQ:   state_next = S_SUM;
      S_SUM:  state_next = S_INS;
      S_INS:  state_next = S_IDLE;
      S_DIV:  if (!st.div_busy) state_next = S_PICK;
      S_PICK: if (st.out_free) state_next = S_IDLE;
      S_EMIT: if (st.out_free && st.idx_last) state_next = S_IDLE;
      S_NONE: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_kind = KIND_NONE;
    case (state)
      S_IDLE: begin
        cmd.latch    = accept;
        cmd.ref_load = accept && (in_func == FUNC_BEGIN);
        if (accept && (in_func == FUNC_END || in_func == FUNC_PICK)) begin
          cmd.idx_clr   = 1'b1;
          cmd.div_start = (in_func == FUNC_PICK) && st.enable && !st.count_zero &&
                          !st.pick_trivial;
        end
      end
      S_DIFF: cmd.diff_en = 1'b1;
      S_SQ:   cmd.sq_en   = 1'b1;
      S_SUM:  cmd.sum_en  = 1'b1;
      S_INS:  cmd.ins_en  = 1'b1;
      S_DIV:  cmd.idx_from_rem = !st.div_busy;
      S_PICK: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = KIND_PICK;
        cmd.cnt_pick = st.out_free && !st.pick_trivial;
      end
      S_EMIT: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = KIND_ENTRY;
        cmd.idx_inc  = st.out_free;
      end
      S_NONE: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = KIND_NONE;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/nksel_mod.sv
// Serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on nksel_pkg for the dividend width.
module nksel_mod #(
  parameter int DIV_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nksel_pkg::PICK_W-1:0]  dividend,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          busy,
  output logic [DIV_W-1:0]              rem
);
  import nksel_pkg::*;

  localparam int STEP_W = $clog2(PICK_W + 1);

  logic [PICK_W-1:0] dvd;
  logic [STEP_W-1:0] steps;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    dsr;

  assign trial = {rem, dvd[PICK_W-1]};
  assign dsr   = {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(PICK_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      // subtract back only when the trial fits
      if (trial >= dsr) rem <= DIV_W'(trial - dsr);
      else rem <= DIV_W'(trial);
    end
  end

endmodule

// File: hw/rtl/nksel_dp.sv
// Datapath of the selector: settings, reference, distance steps, kept list,
// pick counter and output word. Depends on nksel_pkg and nksel_mod.
module nksel_dp #(
  parameter int MAX_KEPT   = 16,
  parameter int COORD_BITS = 22,
  localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int DW = 2 * COORD_BITS + 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nksel_pkg::cmd_t                      cmd,
  output nksel_pkg::status_t                   st,
  input  logic                                 cfg_we,
  input  logic [nksel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nksel_pkg::LOCK_RANGE_W-1:0]   cfg_data,
  input  logic signed [COORD_BITS-1:0]         coord_x,
  input  logic signed [COORD_BITS-1:0]         coord_y,
  input  logic signed [COORD_BITS-1:0]         coord_z,
  input  logic                                 usable,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           kind,
  output logic [IW-1:0]                        rank,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic signed [COORD_BITS-1:0]         out_z,
  output logic [DW-1:0]                        dist_sq,
  output logic                                 last
);
  import nksel_pkg::*;

  localparam int CW   = $clog2(MAX_KEPT + 1);
  localparam int AW   = COORD_BITS + 1;
  localparam int RSQW = 2 * LOCK_RANGE_W;
  localparam int CMPW = (DW > RSQW) ? DW : RSQW;

  logic                    track_enable;
  logic [LOCK_RANGE_W-1:0] lock_range;
  logic [MAX_TGT_W-1:0]    max_targets;
  logic [CW-1:0]           k;

  logic signed [COORD_BITS-1:0] ref_x, ref_y, ref_z;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic                         usable_q;

  logic signed [AW-1:0] dx, dy, dz;
  logic [AW-1:0]        adx, ady, adz;
  logic [DW-1:0]        sqx, sqy, sqz;
  logic [LOCK_RANGE_W-1:0] rng;
  logic [RSQW-1:0]      rsq;
  logic [DW-1:0]        d2;
  logic                 in_range;

  logic signed [COORD_BITS-1:0] kx [MAX_KEPT];
  logic signed [COORD_BITS-1:0] ky [MAX_KEPT];
  logic signed [COORD_BITS-1:0] kz [MAX_KEPT];
  logic [DW-1:0]                kd [MAX_KEPT];
  logic [CW-1:0]                count, cnt_cut, km1;
  logic [MAX_KEPT-1:0]          sel;
  logic                         do_ins;

  logic [PICK_W-1:0] pick_counter;
  logic [IW-1:0]     emit_idx;
  logic              div_busy;
  logic [CW-1:0]     rem;
  logic              out_free;

  // settings
  always_ff @(posedge clk) begin
    if (rst) begin
      track_enable <= 1'b0;
      lock_range   <= RANGE_RESET;
      max_targets  <= MAX_TGT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACK_ENABLE: track_enable <= cfg_data[0];
        CFG_LOCK_RANGE:   lock_range   <= cfg_data;
        CFG_MAX_TARGETS:  max_targets  <= cfg_data[MAX_TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (max_targets == '0) k = CW'(1);
    else if (int'(max_targets) > MAX_KEPT) k = CW'(MAX_KEPT);
    else k = CW'(max_targets);
  end

  // reference and latched word
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
    end else if (cmd.ref_load) begin
      ref_x <= coord_x;
      ref_y <= coord_y;
      ref_z <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cx       <= coord_x;
      cy       <= coord_y;
      cz       <= coord_z;
      usable_q <= usable;
    end
  end

  // distance: difference, square, sum and range test, one step each
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      dx <= AW'(cx) - AW'(ref_x);
      dy <= AW'(cy) - AW'(ref_y);
      dz <= AW'(cz) - AW'(ref_z);
    end
  end

  assign adx = dx[AW-1] ? AW'(-dx) : AW'(dx);
  assign ady = dy[AW-1] ? AW'(-dy) : AW'(dy);
  assign adz = dz[AW-1] ? AW'(-dz) : AW'(dz);
  assign rng = (lock_range < MIN_RANGE) ? MIN_RANGE : lock_range;

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
      sqz <= adz * adz;
      rsq <= rng * rng;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      d2       <= sqx + sqy + sqz;
      in_range <= (CMPW'(sqx + sqy + sqz) <= CMPW'(rsq));
    end
  end

  // insertion: entries at or below the new distance hold, the rest shift down
  assign cnt_cut = (count > k) ? k : count;
  assign km1     = k - CW'(1);

  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      sel[i] = (CW'(i) < cnt_cut) && (kd[i] <= d2);
    end
  end

  assign do_ins = usable_q && in_range && !sel[km1[IW-1:0]];

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_kept
    always_ff @(posedge clk) begin
      if (cmd.ins_en && do_ins && !sel[i]) begin
        if (i == 0) begin
          kx[i] <= cx;
          ky[i] <= cy;
          kz[i] <= cz;
          kd[i] <= d2;
        end else if (sel[(i > 0) ? i - 1 : 0]) begin
          kx[i] <= cx;
          ky[i] <= cy;
          kz[i] <= cz;
          kd[i] <= d2;
        end else begin
          kx[i] <= kx[(i > 0) ? i - 1 : 0];
          ky[i] <= ky[(i > 0) ? i - 1 : 0];
          kz[i] <= kz[(i > 0) ? i - 1 : 0];
          kd[i] <= kd[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ref_load) begin
      count <= '0;
    end else if (cmd.ins_en) begin
      if (do_ins && cnt_cut < k) count <= cnt_cut + CW'(1);
      else count <= cnt_cut;
    end
  end

  // pick index
  nksel_mod #(.DIV_W(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (pick_counter),
    .divisor  (count),
    .busy     (div_busy),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_counter <= '0;
    end else if (cmd.cnt_pick) begin
      pick_counter <= pick_counter + PICK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) emit_idx <= '0;
    else if (cmd.idx_from_rem) emit_idx <= IW'(rem);
    else if (cmd.idx_inc) emit_idx <= emit_idx + IW'(1);
  end

  // output word
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      if (cmd.out_kind == KIND_NONE) begin
        rank    <= '0;
        out_x   <= '0;
        out_y   <= '0;
        out_z   <= '0;
        dist_sq <= '0;
        last    <= 1'b1;
      end else begin
        rank    <= emit_idx;
        out_x   <= kx[emit_idx];
        out_y   <= ky[emit_idx];
        out_z   <= kz[emit_idx];
        dist_sq <= kd[emit_idx];
        last    <= (cmd.out_kind == KIND_PICK) || st.idx_last;
      end
    end
  end

  assign st.enable       = track_enable;
  assign st.count_zero   = (count == '0);
  assign st.pick_trivial = (count <= CW'(1)) || (k == CW'(1));
  assign st.idx_last     = (CW'(emit_idx) == count - CW'(1));
  assign st.div_busy     = div_busy;
  assign st.out_free     = out_free;

`include "nearest_k_target_selector_unit_assert.svh"

  `NKS_ASSERT_IMP(a_count_bound, 1'b1, int'(count) <= MAX_KEPT, "kept count beyond depth")
  `NKS_ASSERT_IMP(a_load_free, cmd.out_load, out_free, "output word overwritten")
  `NKS_ASSERT_NXT(a_ins_fits, cmd.ins_en, count <= k, "kept count beyond K after insert")
  `NKS_ASSERT_IMP(a_rem_bound, cmd.idx_from_rem, rem < count, "pick index beyond kept count")

endmodule

// File: test/testbench.sv
// Testbench for the nearest-K target selector: random and directed scans,
// candidates, end-scan and pick words checked against a scoreboard model.
// Depends on nksel_pkg and nearest_k_target_selector_unit.
`timescale 1ns / 100ps

typedef struct {
  logic [1:0]  kind;
  logic [3:0]  rank;
  logic [21:0] x;
  logic [21:0] y;
  logic [21:0] z;
  logic [45:0] dsq;
  logic        last;
} target_t;

class target_scoreboard;
  bit               enable;
  logic [20:0]      range;
  logic [4:0]       max_tgt;
  logic signed [21:0] ref_x, ref_y, ref_z;
  logic [21:0]      kx[16], ky[16], kz[16];
  logic [45:0]      kd[16];
  int unsigned      count;
  logic [31:0]      pick_cnt;
  target_t          pending[$];
  int               errors;
  int               seen;

  function new();
    enable = 0;
    range = nksel_pkg::RANGE_RESET;
    max_tgt = 1;
    ref_x = 0; ref_y = 0; ref_z = 0;
    count = 0;
    pick_cnt = 0;
    errors = 0;
    seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [20:0] val);
    case (idx)
      nksel_pkg::CFG_TRACK_ENABLE: enable = val[0];
      nksel_pkg::CFG_LOCK_RANGE:   range = val;
      nksel_pkg::CFG_MAX_TARGETS:  max_tgt = val[4:0];
      default: ;
    endcase
  endfunction

  function logic [45:0] sq(logic signed [21:0] a, logic signed [21:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return 46'(d * d);
  endfunction

  function void push(logic [1:0] kd_, int unsigned r, int unsigned i, bit lst);
    target_t t;
    t.kind = kd_;
    t.rank = 4'(r);
    t.x = (kd_ == nksel_pkg::KIND_NONE) ? '0 : kx[i];
    t.y = (kd_ == nksel_pkg::KIND_NONE) ? '0 : ky[i];
    t.z = (kd_ == nksel_pkg::KIND_NONE) ? '0 : kz[i];
    t.dsq = (kd_ == nksel_pkg::KIND_NONE) ? '0 : kd[i];
    t.last = lst;
    pending = {pending, t};
  endfunction

  function void note_word(logic [1:0] fn, logic signed [21:0] cx,
                          logic signed [21:0] cy, logic signed [21:0] cz, bit use_it);
    int unsigned k, pos, i, idx;
    logic [45:0] d2;
    logic [45:0] lim;
    logic [20:0] r;
    k = (max_tgt < 1) ? 1 : (max_tgt > 16 ? 16 : max_tgt);
    case (fn)
      nksel_pkg::FUNC_BEGIN: begin
        ref_x = cx; ref_y = cy; ref_z = cz;
        count = 0;
      end
      nksel_pkg::FUNC_CAND: begin
        if (!enable) return;
        if (count > k) count = k;
        if (!use_it) return;
        d2 = sq(cx, ref_x) + sq(cy, ref_y) + sq(cz, ref_z);
        r = (range > nksel_pkg::MIN_RANGE) ? range : nksel_pkg::MIN_RANGE;
        lim = 46'(r) * 46'(r);
        if (d2 > lim) return;
        if (count >= k && d2 >= kd[count-1]) return;
        pos = 0;
        while (pos < count && kd[pos] <= d2) pos++;
        i = (count < k) ? count : count - 1;
        for (; i > pos; i--) begin
          kx[i] = kx[i-1]; ky[i] = ky[i-1]; kz[i] = kz[i-1]; kd[i] = kd[i-1];
        end
        kx[pos] = cx; ky[pos] = cy; kz[pos] = cz; kd[pos] = d2;
        if (count < k) count++;
      end
      default: begin
        if (!enable || count == 0) begin
          push(nksel_pkg::KIND_NONE, 0, 0, 1);
        end else if (fn == nksel_pkg::FUNC_END) begin
          for (i = 0; i < count; i++) push(nksel_pkg::KIND_ENTRY, i, i, i + 1 == count);
        end else begin
          idx = 0;
          if (count > 1 && k > 1) begin
            idx = pick_cnt % count;
            pick_cnt++;
          end
          push(nksel_pkg::KIND_PICK, idx, idx, 1);
        end
      end
    endcase
  endfunction

  function void check_target(target_t got);
    target_t exp_t;
    seen++;
    if (pending.size() == 0) begin
      $error("unexpected result kind=%0d rank=%0d", got.kind, got.rank);
      errors++;
      return;
    end
    exp_t = pending.pop_front();
    if (got.kind !== exp_t.kind) begin
      $error("kind: expected %0d, got %0d", exp_t.kind, got.kind); errors++;
    end
    if (got.rank !== exp_t.rank) begin
      $error("rank: expected %0d, got %0d", exp_t.rank, got.rank); errors++;
    end
    if (got.x !== exp_t.x) begin
      $error("out_x: expected %h, got %h", exp_t.x, got.x); errors++;
    end
    if (got.y !== exp_t.y) begin
      $error("out_y: expected %h, got %h", exp_t.y, got.y); errors++;
    end
    if (got.z !== exp_t.z) begin
      $error("out_z: expected %h, got %h", exp_t.z, got.z); errors++;
    end
    if (got.dsq !== exp_t.dsq) begin
      $error("dist_sq: expected %h, got %h", exp_t.dsq, got.dsq); errors++;
    end
    if (got.last !== exp_t.last) begin
      $error("last: expected %0d, got %0d", exp_t.last, got.last); errors++;
    end
  endfunction
endclass

module testbench;
  import nksel_pkg::*;

  localparam int WATCHDOG = 20000;
  // register index past the end of the list
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [20:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         func;
  logic signed [21:0] coord_x, coord_y, coord_z;
  logic               usable;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         kind;
  logic [3:0]         rank;
  logic signed [21:0] out_x, out_y, out_z;
  logic [45:0]        dist_sq;
  logic               last;

  target_scoreboard   board;
  bit                 quiet;
  int                 idle_cycles;
  int                 words_in;
  logic signed [21:0] base_x, base_y, base_z;

  nearest_k_target_selector_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .usable(usable),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .rank(rank),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .dist_sq(dist_sq), .last(last)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    board = new();
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; func = '0; coord_x = '0; coord_y = '0; coord_z = '0; usable = 0;
    quiet = 0;
  end

  // Sink side: check results, stall at random in bursts.
  initial begin
    int stall;
    target_t got;
    out_ready = 0;
    stall = 0;
    @(negedge clk);
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.kind = kind; got.rank = rank; got.x = out_x; got.y = out_y; got.z = out_z;
        got.dsq = dist_sq; got.last = last;
        board.check_target(got);
      end
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        out_ready = 0;
      end else begin
        out_ready = 1;
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("nearest_k_target_selector_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_word(logic [1:0] fn, logic signed [21:0] x, logic signed [21:0] y,
                           logic signed [21:0] z, bit u);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1; func = fn; coord_x = x; coord_y = y; coord_z = z; usable = u;
    do @(posedge clk); while (!in_ready);
    board.note_word(fn, x, y, z, u);
    words_in++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Candidate near the reference, sometimes with only a small offset of up to 4.
  function automatic logic signed [21:0] near(logic signed [21:0] b);
    int off;
    off = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) - 4
                                    : int'($urandom_range(0, 8000)) - 4000;
    return 22'(b + off);
  endfunction

  task automatic random_scan(int n);
    base_x = 22'($urandom); base_y = 22'($urandom); base_z = 22'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      base_x = 0; base_y = 0; base_z = 0;
    end
    send_word(FUNC_BEGIN, base_x, base_y, base_z, 1'($urandom));
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_word(FUNC_CAND, 22'($urandom), 22'($urandom), 22'($urandom),
                     1'($urandom));
        1: send_word(FUNC_PICK, 22'($urandom), 22'($urandom), 22'($urandom),
                     1'($urandom));
        default: send_word(FUNC_CAND, near(base_x), near(base_y), near(base_z),
                           $urandom_range(0, 7) != 0);
      endcase
    end
    repeat ($urandom_range(0, 3))
      send_word(FUNC_PICK, 22'($urandom), 22'($urandom), 22'($urandom), 1'($urandom));
    send_word(FUNC_END, 22'($urandom), 22'($urandom), 22'($urandom), 1'($urandom));
  endtask

  initial begin
    words_in = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: disabled block, then extreme coordinates and ties.
    send_word(FUNC_PICK, 0, 0, 0, 1);
    send_word(FUNC_END, 0, 0, 0, 1);
    drain();
    write_reg(CFG_TRACK_ENABLE, 21'h1FFFFF);
    write_reg(CFG_LOCK_RANGE, 21'd0);
    write_reg(CFG_MAX_TARGETS, 21'd3);
    write_reg(CFG_UNUSED, 21'h155555);
    send_word(FUNC_END, 0, 0, 0, 0);
    send_word(FUNC_BEGIN, 22'sh1FFFFF, 22'sh200000, 0, 1);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200000, 0, 1);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200000, 22'sd100, 1);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200000, -22'sd100, 1);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200064, 0, 0);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200000, 22'sd2560, 1);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh200000, 22'sd2561, 1);
    send_word(FUNC_CAND, 22'sh200000, 22'sh1FFFFF, 22'sh1FFFFF, 1);
    send_word(FUNC_PICK, 0, 0, 0, 1);
    send_word(FUNC_PICK, 0, 0, 0, 1);
    send_word(FUNC_END, 0, 0, 0, 1);
    drain();
    write_reg(CFG_LOCK_RANGE, 21'h1FFFFF);
    write_reg(CFG_MAX_TARGETS, 21'd0);
    send_word(FUNC_BEGIN, 22'sh200000, 22'sh200000, 22'sh200000, 0);
    send_word(FUNC_CAND, 22'sh1FFFFF, 22'sh1FFFFF, 22'sh1FFFFF, 1);
    send_word(FUNC_CAND, 22'sh200000, 22'sh200000, 22'sh200001, 1);
    send_word(FUNC_PICK, 0, 0, 0, 1);
    send_word(FUNC_END, 0, 0, 0, 1);
    drain();

    // Random phases over a spread of settings; shrink K mid-scan too.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 10) quiet = 1;
      write_reg(CFG_TRACK_ENABLE, (ph % 5 == 4) ? 21'd0 : 21'd1);
      write_reg(CFG_LOCK_RANGE, ph % 3 == 0 ? 21'h1FFFFF : 21'($urandom_range(0, 6000)));
      write_reg(CFG_MAX_TARGETS,
                ph == 1 ? 21'd31 : ph == 2 ? 21'd16 : 21'($urandom_range(0, 31)));
      for (int s = 0; s < 2; s++) random_scan($urandom_range(2, 9));
      drain();
      if (ph == 5) begin
        write_reg(CFG_MAX_TARGETS, 21'd16);
        base_x = 22'($urandom); base_y = 0; base_z = 0;
        send_word(FUNC_BEGIN, base_x, 0, 0, 1);
        repeat (12) send_word(FUNC_CAND, near(base_x), near(0), near(0), 1);
        drain();
        write_reg(CFG_MAX_TARGETS, 21'd2);
        send_word(FUNC_CAND, base_x, 0, 0, 0);
        send_word(FUNC_PICK, 0, 0, 0, 1);
        send_word(FUNC_END, 0, 0, 0, 1);
        drain();
      end
    end

    $display("covered %0d input words, %0d results checked, K and range swept to extremes",
             words_in, board.seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("nearest_k_target_selector_unit: match");
    end else begin
      $display("nearest_k_target_selector_unit: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/nksel_pkg.sv
hw/rtl/nksel_ctrl.sv
hw/rtl/nksel_mod.sv
hw/rtl/nksel_dp.sv
hw/rtl/nearest_k_target_selector_unit.sv
test/testbench.sv
